[src/stg_pkg.sv]
// ----------------------------------------------------------------------------
// stg_pkg: shared types and codes for the stabilizer tableau gate update
// Word layouts for command and result, function and status codes, control
// word handed from the sequencer to the row update unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 3'd0,
    FUNC_H    = 3'd1,
    FUNC_S    = 3'd2,
    FUNC_SDG  = 3'd3,
    FUNC_CX   = 3'd4,
    FUNC_READ = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_SAME_CX = 2'd2
  } status_e;

  // Config register indexes
  typedef enum logic {
    CFG_ROW_COUNT   = 1'b0,
    CFG_QUBIT_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row_sel;
    logic [IDX_W-1:0]  qubit_a;
    logic [IDX_W-1:0]  qubit_b;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] z_word;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   row_x;
    logic [WORD_W-1:0]   row_z;
    logic                row_sign;
  } out_word_t;

  // Per-cycle control into the row update unit
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  qubit_a;
    logic [IDX_W-1:0]  qubit_b;
    logic              gate_en;   // row is active and a gate is running
    logic              load_hit;  // row is the load target
  } upd_ctrl_t;

endpackage : stg_pkg

`default_nettype wire

[src/stg_cell.sv]
// ----------------------------------------------------------------------------
// stg_cell: one tableau row slot of the rotating chain
// Holds X word, Z word and sign; takes its neighbor's row on each shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stg_cell #(
  parameter int unsigned QN = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic [QN-1:0] x_i,
  input  wire logic [QN-1:0] z_i,
  input  wire logic          s_i,
  output logic      [QN-1:0] x_o,
  output logic      [QN-1:0] z_o,
  output logic               s_o
);

  logic [QN-1:0] x_q, z_q;
  logic          s_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q <= x_i;
      z_q <= z_i;
    end
  end

  // sign bits reset to plus phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= 1'b0;
    end else if (shift_i) begin
      s_q <= s_i;
    end
  end

  assign x_o = x_q;
  assign z_o = z_q;
  assign s_o = s_q;

endmodule : stg_cell

`default_nettype wire

[src/stg_update.sv]
// ----------------------------------------------------------------------------
// stg_update: row update unit at the head of the chain
// Applies H, S, S-dagger, CX or a row load to the row leaving the head cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stg_update #(
  parameter int unsigned QN = 64
) (
  input  wire stg_pkg::upd_ctrl_t ctrl_i,
  input  wire logic [QN-1:0]      load_x_i,
  input  wire logic [QN-1:0]      load_z_i,
  input  wire logic [QN-1:0]      x_i,
  input  wire logic [QN-1:0]      z_i,
  input  wire logic               s_i,
  output logic      [QN-1:0]      x_o,
  output logic      [QN-1:0]      z_o,
  output logic                    s_o
);

  import stg_pkg::*;

  localparam int unsigned QW = $clog2(QN);

  logic [QW-1:0] qa, qb;
  logic          xa, za, xb, zb;

  assign qa = ctrl_i.qubit_a[QW-1:0];
  assign qb = ctrl_i.qubit_b[QW-1:0];
  assign xa = x_i[qa];
  assign za = z_i[qa];
  assign xb = x_i[qb];
  assign zb = z_i[qb];

  // sign rules use the bits before the update
  always_comb begin
    x_o = x_i;
    z_o = z_i;
    s_o = s_i;
    if (ctrl_i.load_hit) begin
      x_o = load_x_i;
      z_o = load_z_i;
      s_o = 1'b0;
    end else if (ctrl_i.gate_en) begin
      case (ctrl_i.func)
        FUNC_H: begin
          x_o[qa] = za;
          z_o[qa] = xa;
          s_o     = s_i ^ (xa & za);
        end
        FUNC_S: begin
          z_o[qa] = za ^ xa;
          s_o     = s_i ^ (xa & za);
        end
        FUNC_SDG: begin
          z_o[qa] = za ^ xa;
          s_o     = s_i ^ (xa & ~za);
        end
        FUNC_CX: begin
          x_o[qb] = xb ^ xa;
          z_o[qa] = za ^ zb;
          s_o     = s_i ^ (xa & zb & ~(xb ^ za));
        end
        default: begin
          s_o = s_i;
        end
      endcase
    end
  end

endmodule : stg_update

`default_nettype wire

[src/stabilizer_tableau_gate_update.sv]
// ----------------------------------------------------------------------------
// stabilizer_tableau_gate_update: stabilizer tableau with Clifford gate update
// Rows live in a circular chain of cells; each valid command rotates the whole
// chain once through the update unit, which applies gates, loads and reads.
//
//   channel  | handshake              | word
//   ---------+------------------------+----------------------------------
//   command  | start_i / busy_o       | cmd_i    (stg_pkg::in_word_t)
//   result   | done_o, one cycle      | result_o (stg_pkg::out_word_t)
//   config   | cfg_we_i, cfg_idx_i    | cfg_data_i (7 bits)
//
// A command with a bad index, bad function or CX on one qubit goes from
// accept straight to done. Any other command makes one full rotation of
// the MAX_ROWS-cell chain through the update unit at one row per cycle.
// busy_o is high from the cycle after accept through the done cycle.
// Reset clears signs, config (row_count 0, qubit_count 64) and control;
// X/Z words are undefined until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stabilizer_tableau_gate_update #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_QUBITS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire stg_pkg::in_word_t         cmd_i,
  output logic                           done_o,
  output stg_pkg::out_word_t             result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [stg_pkg::CFG_W-1:0] cfg_data_i
);

  import stg_pkg::*;

  localparam int unsigned QN    = MAX_QUBITS;
  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [CFG_W-1:0] row_count_q, qubit_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= '0;
      qubit_count_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT:   row_count_q   <= cfg_data_i;
        CFG_QUBIT_COUNT: qubit_count_q <= cfg_data_i;
        default:         row_count_q   <= row_count_q;
      endcase
    end
  end

  // command check at accept
  logic    accept;
  logic    row_bad, qa_bad, qb_bad;
  status_e status_chk;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign row_bad = (32'(cmd_i.row_sel) >= MAX_ROWS);
  assign qa_bad  = ({1'b0, cmd_i.qubit_a} >= qubit_count_q) ||
                   ({1'b0, cmd_i.qubit_a} >= CFG_W'(MAX_QUBITS));
  assign qb_bad  = ({1'b0, cmd_i.qubit_b} >= qubit_count_q) ||
                   ({1'b0, cmd_i.qubit_b} >= CFG_W'(MAX_QUBITS));

  always_comb begin
    status_chk = STATUS_OK;
    case (cmd_i.func)
      FUNC_LOAD, FUNC_READ: begin
        if (row_bad) status_chk = STATUS_RANGE;
      end
      FUNC_H, FUNC_S, FUNC_SDG: begin
        if (qa_bad) status_chk = STATUS_RANGE;
      end
      FUNC_CX: begin
        if (qa_bad || qb_bad) begin
          status_chk = STATUS_RANGE;
        end else if (cmd_i.qubit_a == cmd_i.qubit_b) begin
          status_chk = STATUS_SAME_CX;
        end
      end
      default: begin
        status_chk = STATUS_RANGE;
      end
    endcase
  end

  // latched command
  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  row_q, qa_q, qb_q;
  logic [QN-1:0]     load_x_q, load_z_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= cmd_i.func;
      row_q    <= cmd_i.row_sel;
      qa_q     <= cmd_i.qubit_a;
      qb_q     <= cmd_i.qubit_b;
      load_x_q <= cmd_i.x_word[QN-1:0];
      load_z_q <= cmd_i.z_word[QN-1:0];
    end
  end

  // rotation counter: cell 0 holds row cnt_q during step cnt_q
  logic [CNT_W-1:0] cnt_q;
  logic             cnt_last, row_match, row_active;

  assign cnt_last   = (cnt_q == CNT_W'(MAX_ROWS - 1));
  assign row_match  = (CMP_W'(cnt_q) == CMP_W'(row_q));
  assign row_active = (CMP_W'(cnt_q) < CMP_W'(row_count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= '0;
    end else if (state_q == ST_SHIFT) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = (status_chk == STATUS_OK) ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (cnt_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // chain of cells, head feeds the update unit, update unit feeds the tail
  logic          shift;
  logic [QN-1:0] cell_x [MAX_ROWS];
  logic [QN-1:0] cell_z [MAX_ROWS];
  logic          cell_s [MAX_ROWS];
  logic [QN-1:0] upd_x, upd_z;
  logic          upd_s;
  upd_ctrl_t     ctrl;

  assign shift = (state_q == ST_SHIFT);

  always_comb begin
    ctrl.func     = func_q;
    ctrl.qubit_a  = qa_q;
    ctrl.qubit_b  = qb_q;
    ctrl.gate_en  = row_active && (func_q != FUNC_LOAD) && (func_q != FUNC_READ);
    ctrl.load_hit = row_match && (func_q == FUNC_LOAD);
  end

  stg_update #(
    .QN (QN)
  ) u_update (
    .ctrl_i   (ctrl),
    .load_x_i (load_x_q),
    .load_z_i (load_z_q),
    .x_i      (cell_x[0]),
    .z_i      (cell_z[0]),
    .s_i      (cell_s[0]),
    .x_o      (upd_x),
    .z_o      (upd_z),
    .s_o      (upd_s)
  );

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    logic [QN-1:0] nx, nz;
    logic          ns;
    if (i == MAX_ROWS - 1) begin : g_tail
      assign nx = upd_x;
      assign nz = upd_z;
      assign ns = upd_s;
    end else begin : g_mid
      assign nx = cell_x[i+1];
      assign nz = cell_z[i+1];
      assign ns = cell_s[i+1];
    end
    stg_cell #(
      .QN (QN)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .x_i     (nx),
      .z_i     (nz),
      .s_i     (ns),
      .x_o     (cell_x[i]),
      .z_o     (cell_z[i]),
      .s_o     (cell_s[i])
    );
  end

  // result register: status at accept, row captured as it passes the head
  out_word_t result_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q.status   <= status_chk;
      result_q.row_x    <= '0;
      result_q.row_z    <= '0;
      result_q.row_sign <= 1'b0;
    end else if (shift && row_match && (func_q == FUNC_READ)) begin
      result_q.row_x    <= WORD_W'(cell_x[0]);
      result_q.row_z    <= WORD_W'(cell_z[0]);
      result_q.row_sign <= cell_s[0];
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_DONE);
  assign result_o = result_q;

endmodule : stabilizer_tableau_gate_update

`default_nettype wire
